// File: rtl/core/prht_pkg.sv
// Package for the pair rule hash table: sizes, status codes and the queued command type.
// Depends on nothing; it is used by every module in rtl/core.
package prht_pkg;
	localparam int BUCKETS      = 256;
	localparam int POOL_ENTRIES = 128;
	localparam int BW = $clog2(BUCKETS);
	localparam int PW = $clog2(POOL_ENTRIES);
	localparam int LW = $clog2(POOL_ENTRIES + 1);
	localparam int CW = $clog2(POOL_ENTRIES + 1);
	localparam logic [LW-1:0] NIL = LW'(POOL_ENTRIES);

	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	localparam logic [1:0] ST_UPDATED  = 2'd0;
	localparam logic [1:0] ST_INSERTED = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_CLEARED  = 2'd3;

	typedef struct packed {
		logic        clear;
		logic [31:0] lo;
		logic [31:0] hi;
		logic        flag;
		logic [BW-1:0] bkt;
	} prht_op_t;
endpackage

// File: rtl/core/prht_front.sv
// Front part: takes input transactions, orders the pair and picks the bucket.
// Depends on prht_pkg.
module prht_front import prht_pkg::*; (
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [31:0] id_first,
	input  logic [31:0] id_second,
	input  logic        may_collide,
	output logic        op_valid,
	input  logic        op_ready,
	output prht_op_t    op
);
	logic lt;
	assign lt = id_first < id_second;
	assign op_valid = in_valid;
	assign in_ready = op_ready;
	always_comb begin
		op.clear = (cmd == CMD_CLEAR);
		op.flag  = may_collide;
		if (cmd == CMD_CLEAR) begin
			op.lo = id_first;
			op.hi = id_first;
		end else begin
			op.lo = lt ? id_first : id_second;
			op.hi = lt ? id_second : id_first;
		end
		op.bkt = op.lo[BW-1:0];
	end
endmodule

// File: rtl/core/prht_queue.sv
// Two-entry command queue between the front and the back part.
// Depends on prht_pkg.
module prht_queue import prht_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_valid,
	output logic     wr_ready,
	input  prht_op_t wr_op,
	output logic     rd_valid,
	input  logic     rd_ready,
	output prht_op_t rd_op
);
	prht_op_t mem_q [2];
	logic     wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;
	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_op = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_op;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> !rd) else $error("read of empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr && !rd) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count slip");
endmodule

// File: rtl/core/prht_back.sv
// Back part: sequencer that walks bucket chains in the tables and holds the result register.
// Depends on prht_pkg.
module prht_back import prht_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        op_valid,
	output logic        op_ready,
	input  prht_op_t    op,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [7:0]  removed_count
);
	localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_HEAD = 4'd2, S_EREQ = 4'd3,
		S_ECHK = 4'd4, S_FNXT = 4'd5, S_ALLOC = 4'd6, S_FRD = 4'd7, S_FPOP = 4'd8,
		S_LINK = 4'd9, S_CHEAD = 4'd10, S_CLOAD = 4'd11, S_CREQ = 4'd12, S_CCHK = 4'd13,
		S_CUNL = 4'd14;

	// bucket heads and entry tables; heads are cleared by a pass after reset
	logic [LW-1:0] head_mem [BUCKETS];
	logic [31:0]   lo_mem   [POOL_ENTRIES];
	logic [31:0]   hi_mem   [POOL_ENTRIES];
	logic          flag_mem [POOL_ENTRIES];
	logic [LW-1:0] next_mem [POOL_ENTRIES];

	logic [3:0]    st_q;
	prht_op_t      op_q;
	logic [BW:0]   bkt_q;
	logic [LW-1:0] cur_q, prev_q, free_q, head_rd_q;
	logic [CW-1:0] fresh_q, steps_q;
	logic [31:0]   lo_rd_q, hi_rd_q;
	logic [LW-1:0] nx_rd_q;
	logic [7:0]    rem_q;
	logic [1:0]    st_res_q;

	logic [BW-1:0] bidx;
	logic [PW-1:0] cidx, pidx;
	logic          link_ok, walk_ok, hit, prev_ok;
	assign bidx = op_q.clear ? bkt_q[BW-1:0] : op_q.bkt;
	assign cidx = cur_q[PW-1:0];
	assign pidx = prev_q[PW-1:0];
	assign prev_ok = prev_q < NIL;
	assign link_ok = cur_q < NIL;
	assign walk_ok = link_ok && (steps_q < CW'(POOL_ENTRIES));
	assign hit = op_q.clear ? (lo_rd_q == op_q.lo || hi_rd_q == op_q.lo)
		: (lo_rd_q == op_q.lo && hi_rd_q == op_q.hi);

	assign op_ready = (st_q == S_IDLE) && !out_valid;
	assign status = st_res_q;
	assign removed_count = rem_q;

	// memory reads, registered; data for the address of one cycle is used in the next
	always_ff @(posedge clk) begin
		head_rd_q <= head_mem[bidx];
		lo_rd_q   <= lo_mem[cidx];
		hi_rd_q   <= hi_mem[cidx];
		nx_rd_q   <= next_mem[cidx];
	end

	// in S_CUNL nx_rd_q still holds the old link of the unlinked entry
	always_ff @(posedge clk) begin
		if (st_q == S_INIT) head_mem[bkt_q[BW-1:0]] <= NIL;
		else if (st_q == S_LINK) head_mem[bidx] <= cur_q;
		else if (st_q == S_CUNL && !prev_ok) head_mem[bidx] <= nx_rd_q;
	end

	always_ff @(posedge clk) begin
		if (st_q == S_FNXT && hit) flag_mem[cidx] <= op_q.flag;
		if (st_q == S_LINK) begin
			lo_mem[cidx]   <= op_q.lo;
			hi_mem[cidx]   <= op_q.hi;
			flag_mem[cidx] <= op_q.flag;
			next_mem[cidx] <= head_rd_q;
		end
		if (st_q == S_CCHK && hit) next_mem[cidx] <= free_q;
		if (st_q == S_CUNL && prev_ok) next_mem[pidx] <= nx_rd_q;
	end

	always_ff @(posedge clk) begin
		if (op_valid && op_ready) op_q <= op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_INIT; bkt_q <= '0; cur_q <= NIL; prev_q <= NIL; free_q <= NIL;
			fresh_q <= '0; steps_q <= '0; rem_q <= '0; st_res_q <= ST_UPDATED;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (st_q)
				S_INIT: begin
					bkt_q <= bkt_q + (BW+1)'(1);
					if (bkt_q == (BW+1)'(BUCKETS - 1)) st_q <= S_IDLE;
				end
				S_IDLE: if (op_valid && op_ready) begin
					bkt_q <= '0; steps_q <= '0; rem_q <= '0; prev_q <= NIL;
					st_q <= op.clear ? S_CHEAD : S_HEAD;
				end
				S_HEAD: st_q <= S_EREQ; // head read in flight
				S_EREQ: begin cur_q <= head_rd_q; st_q <= S_ECHK; end
				S_ECHK: st_q <= walk_ok ? S_FNXT : S_ALLOC;
				S_FNXT: begin
					// entry data arrived: compare and step
					if (hit) begin
						st_res_q <= ST_UPDATED; out_valid <= 1'b1; st_q <= S_IDLE;
					end else begin
						cur_q <= nx_rd_q; steps_q <= steps_q + CW'(1); st_q <= S_ECHK;
					end
				end
				S_ALLOC: begin
					if (free_q < NIL) begin
						cur_q <= free_q; st_q <= S_FRD;
					end else if (fresh_q < CW'(POOL_ENTRIES)) begin
						cur_q <= LW'(fresh_q); fresh_q <= fresh_q + CW'(1); st_q <= S_LINK;
					end else begin
						st_res_q <= ST_FULL; out_valid <= 1'b1; st_q <= S_IDLE;
					end
				end
				S_FRD: st_q <= S_FPOP; // link of the free entry in flight
				S_FPOP: begin free_q <= nx_rd_q; st_q <= S_LINK; end
				S_LINK: begin
					st_res_q <= ST_INSERTED; out_valid <= 1'b1; st_q <= S_IDLE;
				end
				S_CHEAD: begin
					if (bkt_q == (BW+1)'(BUCKETS)) begin
						st_res_q <= ST_CLEARED; out_valid <= 1'b1; st_q <= S_IDLE;
					end else begin
						prev_q <= NIL; steps_q <= '0; st_q <= S_CLOAD;
					end
				end
				S_CLOAD: begin cur_q <= head_rd_q; st_q <= S_CREQ; end
				S_CREQ: begin
					if (!walk_ok) begin
						bkt_q <= bkt_q + (BW+1)'(1); st_q <= S_CHEAD;
					end else st_q <= S_CCHK;
				end
				S_CCHK: begin
					if (hit) begin
						free_q <= cur_q;
						if (rem_q != 8'd255) rem_q <= rem_q + 8'd1;
						st_q <= S_CUNL;
					end else begin
						prev_q <= cur_q; cur_q <= nx_rd_q; steps_q <= steps_q + CW'(1);
						st_q <= S_CREQ;
					end
				end
				S_CUNL: begin
					cur_q <= nx_rd_q; steps_q <= steps_q + CW'(1); st_q <= S_CREQ;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)) else $error("result lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_res_q == ST_CLEARED) || (rem_q == 8'd0) || !out_valid) else $error("add count");
	assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= CW'(POOL_ENTRIES)) else $error("pool overrun");
endmodule

// File: rtl/core/pair_rule_hash_table.sv
// Top level of the pair rule hash table: front, queue and back part.
// Depends on prht_pkg, prht_front, prht_queue, prht_back.
// An update walks the bucket chain to the matching entry; an insert walks the whole chain,
// then takes an entry from the free list, else a fresh one, or reports pool full; a clear
// walks every bucket chain and unlinks each matching entry. One transaction at a time in the
// back part. After reset a clearing pass empties the bucket heads; two transactions may wait
// in the queue meanwhile.
module pair_rule_hash_table import prht_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [31:0] id_first,
	input  logic [31:0] id_second,
	input  logic        may_collide,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [7:0]  removed_count
);
	prht_op_t f_op, b_op;
	logic f_valid, f_ready, b_valid, b_ready;
	prht_front u_front (.in_valid, .in_ready, .cmd, .id_first, .id_second,
		.may_collide, .op_valid(f_valid), .op_ready(f_ready), .op(f_op));
	prht_queue u_queue (.clk, .arst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_op(f_op),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_op(b_op));
	prht_back u_back (.clk, .arst_n, .op_valid(b_valid), .op_ready(b_ready), .op(b_op),
		.out_valid, .out_ready, .status, .removed_count);
endmodule

// File: test/tb_pair_rule_hash_table.sv
// Testbench for pair_rule_hash_table: random and directed add/clear traffic with a
// cycle-free behavioral table predicting each status and removed count.
// Depends on prht_pkg and the pair_rule_hash_table RTL.
`timescale 1ns / 100ps

module tb_pair_rule_hash_table;
	import prht_pkg::*;

	typedef struct {
		logic        cmd;
		logic [31:0] id_first;
		logic [31:0] id_second;
		logic        may_collide;
	} rule_req_t;

	typedef struct {
		logic [1:0] status;
		logic [7:0] removed_count;
	} rule_resp_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        cmd;
	logic [31:0] id_first;
	logic [31:0] id_second;
	logic        may_collide;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [7:0]  removed_count;

	pair_rule_hash_table dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .id_first(id_first), .id_second(id_second),
		.may_collide(may_collide),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .removed_count(removed_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Shadow table state; null link is POOL_ENTRIES.
	int unsigned chain_head [BUCKETS];
	logic [31:0] slot_lo [POOL_ENTRIES];
	logic [31:0] slot_hi [POOL_ENTRIES];
	logic        slot_flag [POOL_ENTRIES];
	int unsigned slot_next [POOL_ENTRIES];
	int unsigned free_top;
	int unsigned used_slots;

	rule_req_t  pending_reqs [$];
	rule_resp_t expected_resps [$];
	int unsigned errors;
	bit stim_done = 1'b0;

	// Small ID pool so random adds revisit pairs and clears actually hit.
	logic [31:0] id_pool [16];

	function automatic void table_reset();
		for (int i = 0; i < BUCKETS; i++) chain_head[i] = POOL_ENTRIES;
		for (int i = 0; i < POOL_ENTRIES; i++) begin
			slot_lo[i] = '0; slot_hi[i] = '0; slot_flag[i] = 1'b0;
			slot_next[i] = POOL_ENTRIES;
		end
		free_top = POOL_ENTRIES;
		used_slots = 0;
	endfunction

	function automatic rule_resp_t predict_rule(rule_req_t r);
		rule_resp_t res;
		logic [31:0] lo, hi;
		int unsigned b, cur, slot, steps, prev, nxt, removed;
		res.removed_count = '0;
		if (r.cmd == CMD_ADD) begin
			lo = (r.id_first < r.id_second) ? r.id_first : r.id_second;
			hi = (r.id_first < r.id_second) ? r.id_second : r.id_first;
			b = lo % BUCKETS;
			cur = chain_head[b];
			steps = 0;
			while (cur < POOL_ENTRIES && steps < POOL_ENTRIES) begin
				if (slot_lo[cur] == lo && slot_hi[cur] == hi) begin
					slot_flag[cur] = r.may_collide;
					res.status = ST_UPDATED;
					return res;
				end
				cur = slot_next[cur];
				steps++;
			end
			if (free_top < POOL_ENTRIES) begin
				slot = free_top;
				free_top = slot_next[slot];
			end else if (used_slots < POOL_ENTRIES) begin
				slot = used_slots;
				used_slots++;
			end else begin
				res.status = ST_FULL;
				return res;
			end
			slot_next[slot] = chain_head[b];
			chain_head[b] = slot;
			slot_lo[slot] = lo;
			slot_hi[slot] = hi;
			slot_flag[slot] = r.may_collide;
			res.status = ST_INSERTED;
		end else begin
			removed = 0;
			for (b = 0; b < BUCKETS; b++) begin
				prev = POOL_ENTRIES;
				cur = chain_head[b];
				steps = 0;
				while (cur < POOL_ENTRIES && steps < POOL_ENTRIES) begin
					nxt = slot_next[cur];
					if (slot_lo[cur] == r.id_first || slot_hi[cur] == r.id_first) begin
						if (prev < POOL_ENTRIES) slot_next[prev] = nxt;
						else chain_head[b] = nxt;
						slot_next[cur] = free_top;
						free_top = cur;
						if (removed < 255) removed++;
					end else begin
						prev = cur;
					end
					cur = nxt;
					steps++;
				end
			end
			res.status = ST_CLEARED;
			res.removed_count = removed[7:0];
		end
		return res;
	endfunction

	function automatic void push_rule(logic c, logic [31:0] a, logic [31:0] b, logic f);
		rule_req_t r;
		r.cmd = c; r.id_first = a; r.id_second = b; r.may_collide = f;
		pending_reqs.push_back(r);
	endfunction

	function automatic logic [31:0] pick_id();
		case ($urandom_range(0, 3))
			0: return $urandom();
			default: return id_pool[$urandom_range(0, 15)];
		endcase
	endfunction

	initial begin
		table_reset();
		for (int i = 0; i < 16; i++) id_pool[i] = $urandom();
		id_pool[0] = 32'h0000_0000;
		id_pool[1] = 32'hFFFF_FFFF;
		// directed: extremes, equal IDs, update, swapped order, clears
		push_rule(CMD_ADD, 32'h0, 32'hFFFF_FFFF, 1'b1);
		push_rule(CMD_ADD, 32'hFFFF_FFFF, 32'h0, 1'b0);     // same pair, swapped: update
		push_rule(CMD_ADD, 32'h7, 32'h7, 1'b1);             // equal IDs
		push_rule(CMD_ADD, 32'h107, 32'h7, 1'b0);
		push_rule(CMD_ADD, 32'h207, 32'h207, 1'b1);         // same bucket chain
		push_rule(CMD_ADD, 32'h7, 32'h107, 1'b1);           // update deep in chain
		push_rule(CMD_CLEAR, 32'h7, 32'hFFFF_FFFF, 1'b1);   // removes two
		push_rule(CMD_CLEAR, 32'h1234_5678, 32'h0, 1'b0);   // removes none
		push_rule(CMD_CLEAR, 32'hFFFF_FFFF, 32'h0, 1'b0);
		// fill pool past capacity to hit pool full, then clear a hub
		for (int i = 0; i < 130; i++)
			push_rule(CMD_ADD, 32'hAAAA_0000, 32'h5555_0000 + i, i[0]);
		push_rule(CMD_ADD, 32'h0, 32'h1, 1'b1);             // dropped: full
		push_rule(CMD_CLEAR, 32'hAAAA_0000, 32'h0, 1'b1);   // removes every hub rule
		// random: mostly adds over the small ID pool, some clears
		for (int i = 0; i < 910; i++) begin
			if ($urandom_range(0, 9) == 0)
				push_rule(CMD_CLEAR, pick_id(), $urandom(), $urandom_range(0, 1));
			else
				push_rule(CMD_ADD, pick_id(), pick_id(), $urandom_range(0, 1));
		end
		stim_done = 1'b1;
	end

	// Reset: asserted at the start only.
	initial begin
		errors = 0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Driver: bursts of random length separated by random gaps.
	int unsigned burst_left, gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			cmd <= CMD_ADD;
			id_first <= '0;
			id_second <= '0;
			may_collide <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!in_valid || in_ready) begin
			// previous transaction, if any, was taken at this edge
			if (in_valid && in_ready)
				expected_resps.push_back(predict_rule('{cmd, id_first, id_second, may_collide}));
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				rule_req_t r;
				r = pending_reqs.pop_front();
				in_valid <= 1'b1;
				cmd <= r.cmd;
				id_first <= r.id_first;
				id_second <= r.id_second;
				may_collide <= r.may_collide;
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 20);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stalls on its own pattern: phases of full readiness and of random stalls.
	int unsigned stall_phase;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_phase <= 0;
		end else begin
			stall_phase <= stall_phase + 1;
			if (stall_phase[8]) out_ready <= 1'b1;
			else out_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	// Monitor: compare each result transaction with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_resps.size() == 0) begin
				$display("%0t: unexpected result status=%0d removed=%0d",
					$realtime, status, removed_count);
				errors++;
			end else begin
				rule_resp_t e;
				e = expected_resps.pop_front();
				if (status !== e.status) begin
					$display("%0t: status mismatch expected %0d actual %0d",
						$realtime, e.status, status);
					errors++;
				end
				if (removed_count !== e.removed_count) begin
					$display("%0t: removed_count mismatch expected %0d actual %0d",
						$realtime, e.removed_count, removed_count);
					errors++;
				end
			end
		end
	end

	// Watchdog on idle cycles; a clear walks every bucket chain and the receiver may stall.
	int unsigned idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		wait (stim_done);
		wait (pending_reqs.size() == 0);
		@(posedge clk);
		while (in_valid || expected_resps.size() != 0) @(posedge clk);
		repeat (1200) @(posedge clk);
		if (errors == 0 && expected_resps.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
